// File: hdl/iad_pkg.sv
// package for the integer heading angle block
// holds widths, tangent table and pipeline constants; no dependencies
package iad_pkg;

    localparam int COORD_W_DEFAULT = 16;
    localparam int FIELD_W         = 16;
    localparam int ANGLE_W         = 9;
    localparam int TAN_SCALE       = 10000;
    localparam int SMALL_LIMIT     = 1000;
    localparam int SMALL_GAIN      = 57;
    localparam int TAN_W           = 14;
    localparam int IDX_W           = 4;

    // tangent of 5..45 degrees scaled by 10000
    function automatic logic [TAN_W-1:0] tan_entry(input logic [IDX_W-1:0] idx);
        logic [TAN_W-1:0] v;
        begin
            unique case (idx)
                4'd0:    v = 14'd875;
                4'd1:    v = 14'd1763;
                4'd2:    v = 14'd2679;
                4'd3:    v = 14'd3640;
                4'd4:    v = 14'd4663;
                4'd5:    v = 14'd5774;
                4'd6:    v = 14'd7002;
                4'd7:    v = 14'd8391;
                default: v = 14'd10000;
            endcase
            return v;
        end
    endfunction

endpackage

// File: hdl/iad_divider.sv
// pipelined restoring divider, one quotient bit per stage
// uses iad_pkg; quotient width and divisor width are parameters
module iad_divider
    import iad_pkg::*;
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 17,
    parameter int Q_W   = 15,
    parameter int TAG_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [Q_W-1:0]   quo,
    output logic [TAG_W-1:0] out_tag
);

    localparam int R_W = DEN_W + 1;

    logic             v_reg   [Q_W+1];
    logic [NUM_W-1:0] n_reg   [Q_W+1];
    logic [DEN_W-1:0] d_reg   [Q_W+1];
    logic [R_W-1:0]   r_reg   [Q_W+1];
    logic [Q_W-1:0]   q_reg   [Q_W+1];
    logic [TAG_W-1:0] t_reg   [Q_W+1];

    // stage zero loads the operands; the partial remainder starts at zero
    always_comb
    begin
        v_reg[0] = in_valid;
        n_reg[0] = num;
        d_reg[0] = den;
        r_reg[0] = '0;
        q_reg[0] = '0;
        t_reg[0] = in_tag;
    end

    // one quotient bit per stage, msb first
    for (genvar s = 0; s < Q_W; s++)
    begin : g_stage
        logic [R_W-1:0] trial;
        logic [R_W:0]   diff;
        always_comb
        begin
            trial = {r_reg[s][R_W-2:0], n_reg[s][Q_W-1-s]};
            diff  = {1'b0, trial} - {2'b00, d_reg[s]};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s+1] <= n_reg[s];
                d_reg[s+1] <= d_reg[s];
                t_reg[s+1] <= t_reg[s];
                if (!diff[R_W])
                begin
                    r_reg[s+1] <= diff[R_W-1:0];
                    q_reg[s+1] <= q_reg[s] | (Q_W'(1) << (Q_W-1-s));
                end
                else
                begin
                    r_reg[s+1] <= trial;
                    q_reg[s+1] <= q_reg[s];
                end
            end
        end
    end

    assign out_valid = v_reg[Q_W];
    assign quo       = q_reg[Q_W];
    assign out_tag   = t_reg[Q_W];

endmodule

// File: hdl/integer_atan2_degrees.sv
// top level of the integer heading angle block
// uses iad_pkg and iad_divider
//
// usage: one transaction on the s_axis side carries a start and a target
// point; one transaction on the m_axis side returns the heading in whole
// degrees 0..359 (counterclockwise from +x, y up). identical points give 0.
// the block is a pipeline that takes a new transaction every cycle while the output side is not stalled.
// the pipeline has 2*COORD_WIDTH+28 register stages: one delta stage, one fold
// stage, a scaled tangent divider of COORD_WIDTH+15 stages, a table select
// stage, an interpolation divider of COORD_WIDTH+9 stages, and the output
// register. throughput is one transaction per cycle, set by the fully
// pipelined dividers. when m_axis_tready is low while the output register
// holds a result, the whole pipeline holds and s_axis_tready falls, so
// nothing is lost or repeated. reset clears all valid bits; payloads are
// not reset.
module integer_atan2_degrees
    import iad_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_W_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // from_x [15:0], from_y [31:16], to_x [47:32], to_y [63:48]
    input  logic [4*FIELD_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // angle_deg [8:0], zeros [15:9]
    output logic [15:0]          m_axis_tdata
);

    localparam int D_W   = COORD_WIDTH + 1;   // magnitude of a delta
    localparam int N1_W  = D_W + TAN_W;       // 10000*minor
    localparam int T1_W  = TAN_W + 1;         // quotient up to 10000
    localparam int Q2_W  = 6;                 // small quotients stay below 64

    logic en;
    logic out_v_reg;
    logic [ANGLE_W-1:0] out_a_reg;

    // pipeline advances when the output register is free or drained
    assign en            = !out_v_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {{(16-ANGLE_W){1'b0}}, out_a_reg};

    // stage 1: sign extend and form absolute deltas and quadrant flags
    logic signed [COORD_WIDTH:0] x1, y1, x2, y2, ddx, ddy;
    assign x1 = (COORD_WIDTH+1)'($signed(s_axis_tdata[COORD_WIDTH-1:0]));
    assign y1 = (COORD_WIDTH+1)'($signed(s_axis_tdata[FIELD_W+COORD_WIDTH-1:FIELD_W]));
    assign x2 = (COORD_WIDTH+1)'($signed(s_axis_tdata[2*FIELD_W+COORD_WIDTH-1:2*FIELD_W]));
    assign y2 = (COORD_WIDTH+1)'($signed(s_axis_tdata[3*FIELD_W+COORD_WIDTH-1:3*FIELD_W]));
    assign ddx = x2 - x1;
    assign ddy = y2 - y1;

    logic           s1_v_reg;
    logic [D_W-1:0] s1_dx_reg, s1_dy_reg;
    logic           s1_west_reg, s1_up_reg, s1_down_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dx_reg   <= ddx[COORD_WIDTH] ? D_W'(-ddx) : D_W'(ddx);
            s1_dy_reg   <= ddy[COORD_WIDTH] ? D_W'(-ddy) : D_W'(ddy);
            s1_west_reg <= ddx[COORD_WIDTH];
            s1_up_reg   <= !ddy[COORD_WIDTH] && (ddy != '0);
            s1_down_reg <= ddy[COORD_WIDTH];
        end
    end

    // stage 2: fold into the first octant
    logic           s2_v_reg;
    logic [D_W-1:0] s2_min_reg, s2_maj_reg;
    logic           s2_swap_reg, s2_zero_reg, s2_west_reg, s2_up_reg, s2_down_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_swap_reg <= s1_dy_reg > s1_dx_reg;
            s2_min_reg  <= (s1_dy_reg > s1_dx_reg) ? s1_dx_reg : s1_dy_reg;
            s2_maj_reg  <= (s1_dy_reg > s1_dx_reg) ? s1_dy_reg : s1_dx_reg;
            s2_zero_reg <= (s1_dx_reg == '0) && (s1_dy_reg == '0);
            s2_west_reg <= s1_west_reg;
            s2_up_reg   <= s1_up_reg;
            s2_down_reg <= s1_down_reg;
        end
    end

    // tangent divider: t = 10000*minor / major; minor and major carried in tag
    localparam int TAG1_W = 5 + 2*D_W;
    logic [N1_W-1:0]   n1;
    logic [D_W-1:0]    d1;
    logic [TAG1_W-1:0] tag1_in, tag1_out;
    logic              d1_v;
    logic [T1_W-1:0]   t1;
    logic [N1_W-1:0]   tq_full;

    assign n1      = N1_W'(s2_min_reg) * N1_W'(TAN_SCALE);
    assign d1      = (s2_maj_reg == '0) ? D_W'(1) : s2_maj_reg;
    assign tag1_in = {s2_swap_reg, s2_zero_reg, s2_west_reg, s2_up_reg, s2_down_reg,
                      s2_min_reg, d1};

    // quotient is at most 10000 since minor <= major, so T1_W bits hold it
    iad_divider #(
        .NUM_W (N1_W),
        .DEN_W (D_W),
        .Q_W   (N1_W),
        .TAG_W (TAG1_W)
    ) u_tan_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_v_reg),
        .num       (n1),
        .den       (d1),
        .in_tag    (tag1_in),
        .out_valid (d1_v),
        .quo       (tq_full),
        .out_tag   (tag1_out)
    );
    assign t1 = tq_full[T1_W-1:0];

    // stage: pick the small path or the table segment and form the second division
    logic [D_W-1:0] o_min, o_maj;
    assign o_min = tag1_out[2*D_W-1:D_W];
    assign o_maj = tag1_out[D_W-1:0];

    logic [IDX_W-1:0] seg;
    always_comb
    begin
        seg = 4'd8;
        for (int k = 7; k >= 1; k--)
        begin
            if (15'(tan_entry(IDX_W'(k))) >= t1)
            begin
                seg = IDX_W'(k);
            end
        end
    end

    logic            small_path;
    logic [TAN_W-1:0] lo, span;
    assign small_path = t1 < T1_W'(SMALL_LIMIT);
    assign lo         = tan_entry(seg - 4'd1);
    assign span       = tan_entry(seg) - lo;

    logic            s3_v_reg;
    logic [D_W+7:0]  s3_num_reg;
    logic [D_W-1:0]  s3_den_reg;
    logic [5:0]      s3_base_reg;
    logic [4:0]      s3_flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_v_reg <= d1_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_flags_reg <= tag1_out[TAG1_W-1:2*D_W];
            if (small_path)
            begin
                s3_num_reg  <= (D_W+8)'(o_min) * (D_W+8)'(SMALL_GAIN)
                               + (D_W+8)'(o_maj >> 1);
                s3_den_reg  <= o_maj;
                s3_base_reg <= '0;
            end
            else
            begin
                s3_num_reg  <= (D_W+8)'(5 * (t1 - T1_W'(lo))) + (D_W+8)'(span >> 1);
                s3_den_reg  <= D_W'(span);
                s3_base_reg <= 6'(seg) * 6'd5;
            end
        end
    end

    // both quotients stay below 64, so only the low quotient bits are kept
    localparam int NQ_W = D_W + 8;
    logic [NQ_W-1:0]   n2_shift;
    logic [Q2_W-1:0]   q2;
    logic [NQ_W-1:0]   q2_full;
    logic              d2_v;
    logic [10:0]       tag2_in, tag2_out;
    assign tag2_in = {s3_base_reg, s3_flags_reg};
    assign n2_shift = s3_num_reg;

    iad_divider #(
        .NUM_W (NQ_W),
        .DEN_W (D_W),
        .Q_W   (NQ_W),
        .TAG_W (11)
    ) u_frac_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_v_reg),
        .num       (n2_shift),
        .den       (s3_den_reg),
        .in_tag    (tag2_in),
        .out_valid (d2_v),
        .quo       (q2_full),
        .out_tag   (tag2_out)
    );
    assign q2 = q2_full[Q2_W-1:0];

    // final stage: octant angle, swap and quadrant mapping
    logic [ANGLE_W-1:0] a_oct, a_fold, ang;
    logic f_swap, f_zero, f_west, f_up, f_down;
    assign {f_swap, f_zero, f_west, f_up, f_down} = tag2_out[4:0];
    assign a_oct  = ANGLE_W'(tag2_out[10:5]) + ANGLE_W'(q2);

    always_comb
    begin
        a_fold = f_zero ? '0 : (f_swap ? ANGLE_W'(90) - a_oct : a_oct);
        if (f_west)
        begin
            ang = f_up ? ANGLE_W'(180) - a_fold : a_fold + ANGLE_W'(180);
        end
        else if (f_down)
        begin
            ang = (a_fold == '0) ? '0 : ANGLE_W'(360) - a_fold;
        end
        else
        begin
            ang = a_fold;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= d2_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_a_reg <= ang;
        end
    end

    // result is always a legal heading
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> out_a_reg < ANGLE_W'(360))
        else $error("heading out of range");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(out_a_reg)))
        else $error("stalled result changed");

    // input is taken whenever output side drains
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("pipeline stalled without back pressure");

endmodule
